// ----- src/mvc_pkg.sv -----
// mvc_pkg: shared types and constants for the midi voice to cv glide block
// holds the config struct, the queue command word and the back-end stage words
// no dependencies
package mvc_pkg;

    // register indexes on the config port
    localparam logic [1:0] REG_MIDI_CHANNEL = 2'd0;
    localparam logic [1:0] REG_NOTE_OFFSET  = 2'd1;
    localparam logic [1:0] REG_PITCH_BEND   = 2'd2;
    localparam logic [1:0] REG_CYCLE_LENGTH = 2'd3;

    // register reset values
    localparam logic [4:0]        MIDI_CHANNEL_RST = 5'd0;
    localparam logic [6:0]        NOTE_OFFSET_RST  = 7'd48;
    localparam logic signed [13:0] PITCH_BEND_RST  = 14'sd0;
    localparam logic [6:0]        CYCLE_LENGTH_RST = 7'd64;

    // hard ceiling on samples per word, set by the sample index width
    localparam int SAMPLE_LIMIT = 64;

    // stream word widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // front to back queue depth
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [4:0]        midi_channel;
        logic [6:0]        note_offset;
        logic signed [13:0] pitch_bend;
        logic [6:0]        cycle_length;
    } cfg_t;

    // one classified voice update waiting for playout
    typedef struct packed {
        logic [2:0]  voice;
        logic        gate;
        logic [12:0] vlevel;
        logic [15:0] newp;
        logic [15:0] prev;
        logic        glide;
        logic        neg;
        logic [15:0] mag;
        logic [6:0]  count;
    } cmd_t;

    // back-end stage after issue: scaled step numerator
    typedef struct packed {
        logic [2:0]  voice;
        logic [5:0]  k;
        logic        gate;
        logic [12:0] vlevel;
        logic [15:0] newp;
        logic [15:0] prev;
        logic        active;
        logic        neg;
        logic [22:0] x;
        logic        last;
    } stg1_t;

    // back-end stage after the reciprocal multiply
    typedef struct packed {
        logic [2:0]  voice;
        logic [5:0]  k;
        logic        gate;
        logic [12:0] vlevel;
        logic [15:0] newp;
        logic [15:0] prev;
        logic        active;
        logic        neg;
        logic [15:0] q;
        logic        last;
    } stg2_t;

endpackage

// ----- src/mvc_queue.sv -----
// mvc_queue: short fifo of command words between front and back
// depends on mvc_pkg (cmd_t, QDEPTH)
module mvc_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mvc_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output mvc_pkg::cmd_t head
);

    localparam int PW = (mvc_pkg::QDEPTH > 1) ? $clog2(mvc_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(mvc_pkg::QDEPTH + 1);

    mvc_pkg::cmd_t mem_reg [mvc_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CW'(mvc_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(mvc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(mvc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/mvc_front.sv -----
// mvc_front: takes voice words, works out gate, pitch, velocity and glide setup
// keeps the per-voice previous pitch; depends on mvc_pkg
module mvc_front
#(
    parameter int VOICES    = 8,
    parameter int MAX_CYCLE = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mvc_pkg::cfg_t                     cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mvc_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              push,
    output mvc_pkg::cmd_t                     push_data,
    input  logic                              q_full
);

    localparam int PDEPTH = (VOICES < 8) ? VOICES : 8;
    localparam int IDXW   = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int NLIM   = (MAX_CYCLE < mvc_pkg::SAMPLE_LIMIT) ? MAX_CYCLE
                                                                 : mvc_pkg::SAMPLE_LIMIT;

    logic        in_valid_reg;
    logic [21:0] in_reg;
    logic [15:0] prev_reg [PDEPTH];

    logic [2:0]  voice;
    logic [3:0]  vch;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic        pressed;
    logic        voice_ok;
    logic        advance;
    logic [IDXW-1:0] idx;

    logic signed [7:0]  d;
    logic [8:0]         e;
    logic [15:0]        e_prod;
    logic [6:0]         third;
    logic signed [7:0]  fd3;
    logic signed [19:0] s;
    logic [15:0]        newp;
    logic [15:0]        prev;
    logic [11:0]        v32;
    logic [11:0]        r;
    logic [12:0]        vlevel;
    logic [6:0]         n0;
    logic [6:0]         count;
    logic               gate;

    // unpack the held word
    assign voice   = in_reg[2:0];
    assign vch     = in_reg[6:3];
    assign note    = in_reg[13:7];
    assign vel     = in_reg[20:14];
    assign pressed = in_reg[21];

    assign voice_ok = (32'(voice) < VOICES);
    assign idx      = IDXW'(voice);
    assign advance  = in_valid_reg && (!q_full || !voice_ok);
    assign push     = in_valid_reg && voice_ok && !q_full;
    assign s_tready = !in_valid_reg || advance;

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg <= s_tdata[21:0];
        end
    end

    // gate: key held and channel accepted
    assign gate = pressed && ((cfg.midi_channel == 5'd0) ||
                              ({1'b0, vch} + 5'd1 == cfg.midi_channel));

    // pitch: bend + floor(1024*d/3), with floor(d/3) by reciprocal multiply
    assign d      = $signed({1'b0, note}) - $signed({1'b0, cfg.note_offset});
    assign e      = {d[7], d} + 9'd129;
    assign e_prod = 16'(e) * 16'd171;
    assign third  = e_prod[15:9];
    assign fd3    = $signed({1'b0, third}) - 8'sd43;
    assign s      = 20'($signed(cfg.pitch_bend)) + 20'(d) * 20'sd341 + 20'(fd3);

    always_comb
    begin
        if (s <= 20'sd0)
        begin
            newp = 16'd0;
        end
        else if (s > 20'sd65535)
        begin
            newp = 16'hFFFF;
        end
        else
        begin
            newp = s[15:0];
        end
    end

    // velocity: 32*v + floor(32*v/127), estimate v/4 and one compare fixes the quotient
    assign v32    = {vel, 5'd0};
    assign r      = v32 - 12'd127 * 12'(vel[6:2]);
    assign vlevel = 13'(v32) + 13'(vel[6:2]) + ((r >= 12'd127) ? 13'd1 : 13'd0);

    // samples per word
    assign n0    = (cfg.cycle_length == 7'd0) ? 7'd1 : cfg.cycle_length;
    assign count = (n0 > 7'(NLIM)) ? 7'(NLIM) : n0;

    // glide setup against the stored pitch
    assign prev = prev_reg[idx];

    always_comb
    begin
        push_data.voice  = voice;
        push_data.gate   = gate;
        push_data.vlevel = vlevel;
        push_data.newp   = newp;
        push_data.prev   = prev;
        push_data.glide  = (prev != 16'd0) && (newp != 16'd0) && (newp != prev);
        push_data.neg    = (newp < prev);
        push_data.mag    = (newp < prev) ? (prev - newp) : (newp - prev);
        push_data.count  = count;
    end

    // previous pitch per voice
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PDEPTH; i++)
            begin
                prev_reg[i] <= 16'd0;
            end
        end
        else if (push)
        begin
            prev_reg[idx] <= newp;
        end
    end

endmodule

// ----- src/mvc_back.sv -----
// mvc_back: plays each queued command out as one sample per clock unless the output stalls
// issue counter, glide step multiply, reciprocal divide, output register; uses mvc_pkg
module mvc_back
#(
    parameter int RESPONSE = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  mvc_pkg::cmd_t                   head,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mvc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    // 2^30 / RESPONSE rounded up; exact floor for numerators below 2^23
    localparam logic [31:0] RECIP = 32'(((64'd1 << 30) + RESPONSE - 1) / RESPONSE);

    logic [5:0]  k_reg, k_next;
    logic        v1_reg, v2_reg, v3_reg;
    mvc_pkg::stg1_t s1_reg, s1_next;
    mvc_pkg::stg2_t s2_reg, s2_next;
    logic [mvc_pkg::OUT_TDATA_W-1:0] out_reg;
    logic        last_reg;

    logic en1, en2, en3;
    logic issue;
    logic last_k;
    logic [54:0] prod;
    logic [15:0] pitch;

    // elastic stage enables
    assign en3   = !v3_reg || m_tready;
    assign en2   = !v2_reg || en3;
    assign en1   = !v1_reg || en2;
    assign issue = head_valid && en1;
    assign last_k = ((7'(k_reg) + 7'd1) == head.count);
    assign pop   = issue && last_k;

    // sample counter
    always_comb
    begin
        k_next = k_reg;
        if (issue)
        begin
            k_next = last_k ? 6'd0 : k_reg + 6'd1;
        end
    end

    // issue stage: |diff|*k, biased for the floor of a negative step
    always_comb
    begin
        s1_next.voice  = head.voice;
        s1_next.k      = k_reg;
        s1_next.gate   = head.gate;
        s1_next.vlevel = head.vlevel;
        s1_next.newp   = head.newp;
        s1_next.prev   = head.prev;
        s1_next.active = head.glide && ({26'd0, k_reg} < 32'(RESPONSE));
        s1_next.neg    = head.neg;
        s1_next.x      = 23'(head.mag) * 23'(k_reg)
                         + (head.neg ? 23'(RESPONSE - 1) : 23'd0);
        s1_next.last   = last_k;
    end

    // divide stage: multiply by the reciprocal
    assign prod = 55'(s1_reg.x) * 55'(RECIP);

    always_comb
    begin
        s2_next.voice  = s1_reg.voice;
        s2_next.k      = s1_reg.k;
        s2_next.gate   = s1_reg.gate;
        s2_next.vlevel = s1_reg.vlevel;
        s2_next.newp   = s1_reg.newp;
        s2_next.prev   = s1_reg.prev;
        s2_next.active = s1_reg.active;
        s2_next.neg    = s1_reg.neg;
        s2_next.q      = prod[45:30];
        s2_next.last   = s1_reg.last;
    end

    // output stage: glide sample or held pitch
    always_comb
    begin
        if (s2_reg.active)
        begin
            pitch = s2_reg.neg ? (s2_reg.prev - s2_reg.q) : (s2_reg.prev + s2_reg.q);
        end
        else
        begin
            pitch = s2_reg.newp;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= 6'd0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (en1)
            begin
                v1_reg <= head_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg <= s1_next;
        end
        if (en2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (en3 && v2_reg)
        begin
            out_reg  <= {1'b0, s2_reg.vlevel, pitch, s2_reg.gate, s2_reg.k, s2_reg.voice};
            last_reg <= s2_reg.last;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- src/midi_voice_to_cv_glide.sv -----
// midi_voice_to_cv_glide: voice word in, cycle_length cv samples out, one per clock unless stalled
// path: a taken word goes through the queue, then 3 stages (issue, divide, output) to its first sample
// throughput: one sample per clock unless stalled; a word occupies the playout counter for n samples,
// n = cycle_length clamped to 1..min(MAX_CYCLE, 64); input overlaps playout until the queue is full
// reset: config registers to defaults, previous pitch of every voice to 0, pipeline empty
// depends on mvc_pkg, mvc_front, mvc_queue, mvc_back
module midi_voice_to_cv_glide
#(
    parameter int VOICES    = 8,
    parameter int RESPONSE  = 16,
    parameter int MAX_CYCLE = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // voice words in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // voice[2:0], voice_channel[6:3], note_number[13:7], note_velocity[20:14],
    // pressed[21], zero pad[23:22]
    input  logic [mvc_pkg::IN_TDATA_W-1:0]  s_tdata,
    // samples out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_voice[2:0], sample_index[8:3], gate[9], pitch_cv[25:10],
    // velocity_level[38:26], zero pad[39]
    output logic [mvc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    mvc_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_sel;

    logic          push;
    mvc_pkg::cmd_t push_data;
    logic          q_full;
    logic          pop;
    logic          head_valid;
    mvc_pkg::cmd_t head;

    // config registers
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.midi_channel <= mvc_pkg::MIDI_CHANNEL_RST;
            cfg_reg.note_offset  <= mvc_pkg::NOTE_OFFSET_RST;
            cfg_reg.pitch_bend   <= mvc_pkg::PITCH_BEND_RST;
            cfg_reg.cycle_length <= mvc_pkg::CYCLE_LENGTH_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                mvc_pkg::REG_MIDI_CHANNEL: cfg_reg.midi_channel <= pwdata[4:0];
                mvc_pkg::REG_NOTE_OFFSET:  cfg_reg.note_offset  <= pwdata[6:0];
                mvc_pkg::REG_PITCH_BEND:   cfg_reg.pitch_bend   <= $signed(pwdata[13:0]);
                mvc_pkg::REG_CYCLE_LENGTH: cfg_reg.cycle_length <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_sel)
            mvc_pkg::REG_MIDI_CHANNEL: prdata = {27'd0, cfg_reg.midi_channel};
            mvc_pkg::REG_NOTE_OFFSET:  prdata = {25'd0, cfg_reg.note_offset};
            mvc_pkg::REG_PITCH_BEND:   prdata = {18'd0, cfg_reg.pitch_bend};
            mvc_pkg::REG_CYCLE_LENGTH: prdata = {25'd0, cfg_reg.cycle_length};
            default:                   prdata = 32'd0;
        endcase
    end

    // front: classify and set up glide
    mvc_front
    #(
        .VOICES    (VOICES),
        .MAX_CYCLE (MAX_CYCLE)
    )
    u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // command queue
    mvc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: sample playout
    mvc_back
    #(
        .RESPONSE (RESPONSE)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- bench/tb_midi_voice_to_cv_glide.sv -----
// tb_midi_voice_to_cv_glide: self-checking bench for the midi voice to cv glide block
// drives voice words in, predicts every cv sample and checks each output word against it
// depends on mvc_pkg and midi_voice_to_cv_glide
module tb_midi_voice_to_cv_glide;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VOICES   = 8;
    localparam int GLIDE_STEPS  = 16;
    localparam int MAX_SAMPLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;

    // input word layout, lowest field last
    typedef struct packed {
        logic [1:0] pad;
        logic       pressed;
        logic [6:0] vel;
        logic [6:0] note;
        logic [3:0] chan;
        logic [2:0] voice;
    } voice_word_t;

    // output word layout, lowest field last
    typedef struct packed {
        logic        pad;
        logic [12:0] level;
        logic [15:0] pitch;
        logic        gate;
        logic [5:0]  idx;
        logic [2:0]  voice;
    } cv_word_t;

    typedef struct packed {
        logic [2:0]  voice;
        logic [5:0]  idx;
        logic        gate;
        logic [15:0] pitch;
        logic [12:0] level;
        logic        last;
    } cv_sample_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [3:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    // voice[2:0], voice_channel[6:3], note_number[13:7], note_velocity[20:14], pressed[21]
    logic [mvc_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // out_voice[2:0], sample_index[8:3], gate[9], pitch_cv[25:10], velocity_level[38:26]
    logic [mvc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // predictor copy of the registers and the per-voice glide origin
    logic [4:0]         cfg_channel;
    logic [6:0]         cfg_offset;
    logic signed [13:0] cfg_bend;
    logic [6:0]         cfg_len;
    logic [15:0]        glide_prev [NUM_VOICES];

    cv_sample_t pending_samples[$];
    int         error_count;
    int         idle_pct;
    int         hold_left;
    int         quiet_cycles;

    midi_voice_to_cv_glide uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int floor_div(input int num, input int den);
        int q;
        q = num / den;
        if ((num % den != 0) && (num < 0))
            q = q - 1;
        return q;
    endfunction

    // work out the samples that one voice word produces
    function automatic void predict_cycle(input voice_word_t w);
        int         bend;
        int         total;
        int         newp;
        int         prev;
        int         diff;
        int         n;
        int         p;
        logic       gate;
        cv_sample_t s;
        bend  = int'(cfg_bend);
        gate  = w.pressed && (cfg_channel == 0 || int'(w.chan) + 1 == int'(cfg_channel));
        total = 12 * bend + 4096 * (int'(w.note) - int'(cfg_offset));
        newp  = total / 12;
        if (newp < 0)
            newp = 0;
        if (newp > 65535)
            newp = 65535;
        n = int'(cfg_len);
        if (n < 1)
            n = 1;
        if (n > MAX_SAMPLES)
            n = MAX_SAMPLES;
        if (n > mvc_pkg::SAMPLE_LIMIT)
            n = mvc_pkg::SAMPLE_LIMIT;
        prev = int'(glide_prev[w.voice]);
        diff = newp - prev;
        glide_prev[w.voice] = newp[15:0];
        for (int k = 0; k < n; k++)
        begin
            p = newp;
            if (prev != 0 && newp != 0 && diff != 0 && k < GLIDE_STEPS)
                p = prev + floor_div(diff * k, GLIDE_STEPS);
            s.voice = w.voice;
            s.idx   = k[5:0];
            s.gate  = gate;
            s.pitch = p[15:0];
            s.level = 13'((int'(w.vel) * 4096) / 127);
            s.last  = (k + 1 == n);
            pending_samples.push_back(s);
        end
    endfunction

    // output side: random stall bursts
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            m_tready <= 1'b0;
            hold_left = $urandom_range(0, 4);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // compare each accepted sample word with the oldest prediction
    always @(posedge clk)
    begin
        cv_word_t   got;
        cv_sample_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = cv_word_t'(m_tdata);
            if (pending_samples.size() == 0)
            begin
                $error("sample word with no prediction: voice %0d index %0d",
                       got.voice, got.idx);
                error_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                check_field("out_voice", int'(want.voice), int'(got.voice));
                check_field("sample_index", int'(want.idx), int'(got.idx));
                check_field("gate", int'(want.gate), int'(got.gate));
                check_field("pitch_cv", int'(want.pitch), int'(got.pitch));
                check_field("velocity_level", int'(want.level), int'(got.level));
                check_field("last", int'(want.last), int'(m_tlast));
            end
        end
    end

    // watchdog on cycles with no word moving on either stream
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // send one voice word, with an optional random gap ahead of it
    task automatic send_voice(input logic [2:0] voice, input logic [3:0] chan,
                              input logic [6:0] note, input logic [6:0] vel,
                              input logic pressed);
        voice_word_t w;
        int          gap;
        w.pad     = 2'b00;
        w.pressed = pressed;
        w.vel     = vel;
        w.note    = note;
        w.chan    = chan;
        w.voice   = voice;
        @(negedge clk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        predict_cycle(w);
    endtask

    // stop sending and let every predicted sample come out
    task automatic drain_block;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        drain_block();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mvc_pkg::REG_MIDI_CHANNEL: cfg_channel = value[4:0];
            mvc_pkg::REG_NOTE_OFFSET:  cfg_offset  = value[6:0];
            mvc_pkg::REG_PITCH_BEND:   cfg_bend    = value[13:0];
            mvc_pkg::REG_CYCLE_LENGTH: cfg_len     = value[6:0];
            default: ;
        endcase
    endtask

    task automatic send_random_voice;
        logic [3:0] chan;
        logic [6:0] note;
        chan = 4'($urandom_range(0, 15));
        if (cfg_channel != 0 && cfg_channel <= 16 && $urandom_range(0, 1) == 1)
            chan = 4'(cfg_channel - 1);
        if ($urandom_range(0, 9) < 7)
            note = 7'($urandom_range(cfg_offset, 127));
        else
            note = 7'($urandom_range(0, 127));
        send_voice(3'($urandom_range(0, NUM_VOICES - 1)), chan, note,
                   7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    endtask

    // reset settings, field extremes and the glide cases
    task automatic test_defaults;
        send_voice(3'd0, 4'd0, 7'd0, 7'd0, 1'b0);
        send_voice(3'd7, 4'd15, 7'd127, 7'd127, 1'b1);
        // downward then upward glide, then a repeat with no glide
        send_voice(3'd7, 4'd5, 7'd60, 7'd64, 1'b1);
        send_voice(3'd7, 4'd10, 7'd72, 7'd1, 1'b1);
        send_voice(3'd7, 4'd10, 7'd72, 7'd100, 1'b1);
        // stored pitch zero, then new pitch zero
        send_voice(3'd0, 4'd3, 7'd60, 7'd126, 1'b1);
        send_voice(3'd0, 4'd3, 7'd30, 7'd2, 1'b0);
    endtask

    // cycle length at and beyond its limits, glide cut short
    task automatic test_cycle_length;
        write_reg(mvc_pkg::REG_CYCLE_LENGTH, 32'd1);
        send_voice(3'd1, 4'd0, 7'd50, 7'd90, 1'b1);
        write_reg(mvc_pkg::REG_CYCLE_LENGTH, 32'd0);
        send_voice(3'd1, 4'd0, 7'd70, 7'd90, 1'b1);
        write_reg(mvc_pkg::REG_CYCLE_LENGTH, 32'd5);
        send_voice(3'd1, 4'd0, 7'd40, 7'd90, 1'b1);
        write_reg(mvc_pkg::REG_CYCLE_LENGTH, 32'd127);
        send_voice(3'd1, 4'd0, 7'd90, 7'd90, 1'b1);
        write_reg(mvc_pkg::REG_CYCLE_LENGTH, 32'd17);
        send_voice(3'd1, 4'd0, 7'd52, 7'd90, 1'b1);
    endtask

    // channel filter, including settings no channel can match
    task automatic test_channel_select;
        write_reg(mvc_pkg::REG_CYCLE_LENGTH, 32'd4);
        write_reg(mvc_pkg::REG_MIDI_CHANNEL, 32'd1);
        send_voice(3'd3, 4'd0, 7'd64, 7'd80, 1'b1);
        send_voice(3'd3, 4'd1, 7'd64, 7'd80, 1'b1);
        write_reg(mvc_pkg::REG_MIDI_CHANNEL, 32'd16);
        send_voice(3'd4, 4'd15, 7'd64, 7'd80, 1'b1);
        send_voice(3'd4, 4'd14, 7'd64, 7'd80, 1'b1);
        write_reg(mvc_pkg::REG_MIDI_CHANNEL, 32'd17);
        send_voice(3'd5, 4'd15, 7'd64, 7'd80, 1'b1);
        write_reg(mvc_pkg::REG_MIDI_CHANNEL, 32'd31);
        send_voice(3'd5, 4'd0, 7'd64, 7'd80, 1'b1);
        write_reg(mvc_pkg::REG_MIDI_CHANNEL, 32'd0);
    endtask

    // offset and bend extremes, truncation toward zero and clamping at zero
    task automatic test_pitch_range;
        write_reg(mvc_pkg::REG_NOTE_OFFSET, 32'd0);
        write_reg(mvc_pkg::REG_PITCH_BEND, 32'd8191);
        send_voice(3'd2, 4'd0, 7'd127, 7'd50, 1'b1);
        write_reg(mvc_pkg::REG_PITCH_BEND, 32'hFFFF_E000);
        send_voice(3'd2, 4'd0, 7'd127, 7'd50, 1'b1);
        write_reg(mvc_pkg::REG_PITCH_BEND, 32'hFFFF_FFFF);
        send_voice(3'd2, 4'd0, 7'd0, 7'd50, 1'b1);
        send_voice(3'd2, 4'd0, 7'd1, 7'd50, 1'b1);
        write_reg(mvc_pkg::REG_NOTE_OFFSET, 32'd127);
        write_reg(mvc_pkg::REG_PITCH_BEND, 32'd8191);
        send_voice(3'd6, 4'd0, 7'd0, 7'd50, 1'b1);
        write_reg(mvc_pkg::REG_PITCH_BEND, 32'd4096);
        send_voice(3'd6, 4'd0, 7'd127, 7'd50, 1'b1);
    endtask

    // random settings per phase, random voice words, varied stalls
    task automatic test_random_traffic;
        int sel;
        for (int phase = 0; phase < 8; phase++)
        begin
            sel = $urandom_range(0, 2);
            idle_pct = (sel == 0) ? 0 : ((sel == 1) ? 15 : 40);
            sel = $urandom_range(0, 9);
            if (sel < 4)
                write_reg(mvc_pkg::REG_MIDI_CHANNEL, 32'd0);
            else if (sel < 9)
                write_reg(mvc_pkg::REG_MIDI_CHANNEL, $urandom_range(1, 16));
            else
                write_reg(mvc_pkg::REG_MIDI_CHANNEL, $urandom_range(17, 31));
            if ($urandom_range(0, 3) != 0)
                write_reg(mvc_pkg::REG_NOTE_OFFSET, $urandom_range(24, 72));
            else
                write_reg(mvc_pkg::REG_NOTE_OFFSET, $urandom_range(0, 127));
            if ($urandom_range(0, 3) != 0)
                write_reg(mvc_pkg::REG_PITCH_BEND,
                          32'($signed($urandom_range(0, 8192)) - 4096));
            else
                write_reg(mvc_pkg::REG_PITCH_BEND, $urandom_range(0, 16383));
            sel = $urandom_range(0, 19);
            if (sel < 15)
                write_reg(mvc_pkg::REG_CYCLE_LENGTH, $urandom_range(1, 24));
            else if (sel < 18)
                write_reg(mvc_pkg::REG_CYCLE_LENGTH, 32'd64);
            else
                write_reg(mvc_pkg::REG_CYCLE_LENGTH,
                          (sel == 18) ? 32'd0 : $urandom_range(65, 127));
            for (int i = 0; i < 33; i++)
            begin
                send_random_voice();
                // hold off once until every sample has come out
                if (phase == 3 && i == 16)
                    drain_block();
            end
        end
    endtask

    // closing stretch with both sides always ready
    task automatic test_quiet_stream;
        idle_pct = 0;
        write_reg(mvc_pkg::REG_MIDI_CHANNEL, 32'd0);
        write_reg(mvc_pkg::REG_NOTE_OFFSET, 32'd36);
        write_reg(mvc_pkg::REG_PITCH_BEND, 32'd0);
        write_reg(mvc_pkg::REG_CYCLE_LENGTH, 32'd8);
        for (int i = 0; i < 25; i++)
            send_random_voice();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        idle_pct    = 20;
        hold_left   = 0;
        error_count = 0;
        quiet_cycles = 0;
        cfg_channel = mvc_pkg::MIDI_CHANNEL_RST;
        cfg_offset  = mvc_pkg::NOTE_OFFSET_RST;
        cfg_bend    = mvc_pkg::PITCH_BEND_RST;
        cfg_len     = mvc_pkg::CYCLE_LENGTH_RST;
        for (int v = 0; v < NUM_VOICES; v++)
            glide_prev[v] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_cycle_length();
        test_channel_select();
        test_pitch_range();
        test_random_traffic();
        test_quiet_stream();

        drain_block();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
